[rtl/vbox_pkg.sv]
// ----------------------------------------------------------------------------
// vbox_pkg: shared types and helpers for the voxel box statistics block
// Widths of samples, coordinates and accumulators, the item passed from the
// scan counter to the statistics stage, and the box extent decode.
// ----------------------------------------------------------------------------
`default_nettype none

package vbox_pkg;

  localparam int COORD_BITS  = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int SIZE_BITS   = 11;
  localparam int SUM_BITS    = 47;
  localparam int MOMENT_BITS = 57;
  localparam int PROD_BITS   = SAMPLE_BITS + COORD_BITS + 1;

  // Output field widths
  localparam int VALUE_W  = 16;
  localparam int POS_W    = 10;
  localparam int SUM_W    = 46;
  localparam int MOMENT_W = 56;
  localparam int RESULT_W = 2 * VALUE_W + 6 * POS_W + SUM_W + 3 * MOMENT_W;
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - RESULT_W;

  localparam int SIZE_CAP = 1 << COORD_BITS;

  typedef logic [COORD_BITS-1:0]         coord_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SIZE_BITS-1:0]          size_t;

  // One voxel with its local coordinates; last marks the box's final voxel
  typedef struct packed {
    sample_t value;
    coord_t  x;
    coord_t  y;
    coord_t  z;
    logic    last;
  } voxel_item_t;

  // Last local index along an axis: zero counts as one, large sizes saturate
  function automatic coord_t last_index(input size_t n);
    coord_t idx;
    if (n == '0) begin
      idx = '0;
    end else if (n > SIZE_BITS'(SIZE_CAP)) begin
      idx = COORD_BITS'(SIZE_CAP - 1);
    end else begin
      idx = COORD_BITS'(n - SIZE_BITS'(1));
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[rtl/vbox_scan.sv]
// ----------------------------------------------------------------------------
// vbox_scan: input register and local coordinate counters
// Tags each accepted voxel with its x/y/z position inside the box and flags
// the box's last voxel, then holds it until the statistics stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module vbox_scan (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire vbox_pkg::sample_t     s_value,
  input  wire vbox_pkg::size_t       size_x,
  input  wire vbox_pkg::size_t       size_y,
  input  wire vbox_pkg::size_t       size_z,
  input  wire logic                  take,
  output logic                       item_valid,
  output vbox_pkg::voxel_item_t      item
);
  import vbox_pkg::*;

  coord_t count_x;
  coord_t count_y;
  coord_t count_z;
  logic   end_x;
  logic   end_y;
  logic   end_z;
  logic   accept;

  // Greater-or-equal so a shrunk extent closes the row/plane/box early
  assign end_x  = count_x >= last_index(size_x);
  assign end_y  = count_y >= last_index(size_y);
  assign end_z  = count_z >= last_index(size_z);

  assign s_tready = !item_valid || take;
  assign accept   = s_tvalid && s_tready;

  // Coordinate counters, x fastest
  always_ff @(posedge clk) begin
    if (rst) begin
      count_x <= '0;
      count_y <= '0;
      count_z <= '0;
    end else if (accept) begin
      if (end_x && end_y && end_z) begin
        count_x <= '0;
        count_y <= '0;
        count_z <= '0;
      end else if (!end_x) begin
        count_x <= count_x + COORD_BITS'(1);
      end else begin
        count_x <= '0;
        if (!end_y) begin
          count_y <= count_y + COORD_BITS'(1);
        end else begin
          count_y <= '0;
          count_z <= count_z + COORD_BITS'(1);
        end
      end
    end
  end

  // Input register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item.value <= s_value;
      item.x     <= count_x;
      item.y     <= count_y;
      item.z     <= count_z;
      item.last  <= end_x && end_y && end_z;
    end
  end

endmodule

`default_nettype wire

[rtl/vbox_stats.sv]
// ----------------------------------------------------------------------------
// vbox_stats: running extrema, sum and first moments with result register
// Folds one voxel per cycle (a final voxel waits on an untaken result) into the box statistics;
// on the box's last voxel loads the packed result into the output register and starts a new box.
// ----------------------------------------------------------------------------
`default_nettype none

module vbox_stats (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  input  wire vbox_pkg::voxel_item_t      item,
  output logic                            take,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [vbox_pkg::TDATA_W-1:0]    m_tdata
);
  import vbox_pkg::*;

  logic                          first;
  sample_t                       run_max;
  coord_t                        max_x, max_y, max_z;
  sample_t                       run_min;
  coord_t                        min_x, min_y, min_z;
  logic signed [SUM_BITS-1:0]    acc_sum;
  logic signed [MOMENT_BITS-1:0] acc_mx, acc_my, acc_mz;

  logic                          upd_max, upd_min;
  sample_t                       run_max_next, run_min_next;
  coord_t                        max_x_next, max_y_next, max_z_next;
  coord_t                        min_x_next, min_y_next, min_z_next;
  logic signed [PROD_BITS-1:0]   prod_x, prod_y, prod_z;
  logic signed [SUM_BITS-1:0]    acc_sum_next;
  logic signed [MOMENT_BITS-1:0] acc_mx_next, acc_my_next, acc_mz_next;
  logic                          load;

  // A final voxel waits only while an untaken result sits in the output
  assign take = item_valid && (!item.last || !m_tvalid || m_tready);
  assign load = take && item.last;

  // Extrema: strict compare keeps the earliest voxel on ties
  assign upd_max      = first || (item.value > run_max);
  assign upd_min      = first || (item.value < run_min);
  assign run_max_next = upd_max ? item.value : run_max;
  assign max_x_next   = upd_max ? item.x : max_x;
  assign max_y_next   = upd_max ? item.y : max_y;
  assign max_z_next   = upd_max ? item.z : max_z;
  assign run_min_next = upd_min ? item.value : run_min;
  assign min_x_next   = upd_min ? item.x : min_x;
  assign min_y_next   = upd_min ? item.y : min_y;
  assign min_z_next   = upd_min ? item.z : min_z;

  // Coordinate-weighted products, one small multiply per axis
  assign prod_x = PROD_BITS'(item.value) * $signed({1'b0, item.x});
  assign prod_y = PROD_BITS'(item.value) * $signed({1'b0, item.y});
  assign prod_z = PROD_BITS'(item.value) * $signed({1'b0, item.z});

  // Accumulators
  assign acc_sum_next = acc_sum + SUM_BITS'(item.value);
  assign acc_mx_next  = acc_mx + MOMENT_BITS'(prod_x);
  assign acc_my_next  = acc_my + MOMENT_BITS'(prod_y);
  assign acc_mz_next  = acc_mz + MOMENT_BITS'(prod_z);

  // Running state; cleared after the box's last voxel
  always_ff @(posedge clk) begin
    if (rst) begin
      first   <= 1'b1;
      acc_sum <= '0;
      acc_mx  <= '0;
      acc_my  <= '0;
      acc_mz  <= '0;
    end else if (take) begin
      if (item.last) begin
        first   <= 1'b1;
        acc_sum <= '0;
        acc_mx  <= '0;
        acc_my  <= '0;
        acc_mz  <= '0;
      end else begin
        first   <= 1'b0;
        acc_sum <= acc_sum_next;
        acc_mx  <= acc_mx_next;
        acc_my  <= acc_my_next;
        acc_mz  <= acc_mz_next;
      end
    end
  end

  // Extrema payload; ignored while first is set
  always_ff @(posedge clk) begin
    if (take) begin
      run_max <= run_max_next;
      max_x   <= max_x_next;
      max_y   <= max_y_next;
      max_z   <= max_z_next;
      run_min <= run_min_next;
      min_x   <= min_x_next;
      min_y   <= min_y_next;
      min_z   <= min_z_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload, first field in the lowest bits
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {PAD_W'(0),
                  acc_mz_next[MOMENT_W-1:0],
                  acc_my_next[MOMENT_W-1:0],
                  acc_mx_next[MOMENT_W-1:0],
                  acc_sum_next[SUM_W-1:0],
                  min_z_next, min_y_next, min_x_next,
                  run_min_next,
                  max_z_next, max_y_next, max_x_next,
                  run_max_next};
    end
  end

endmodule

`default_nettype wire

[rtl/voxel_box_extrema_and_moments.sv]
// ----------------------------------------------------------------------------
// voxel_box_extrema_and_moments: per-box min/max, sum and first moments
// Top level: configuration registers and the two-stage statistics datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Set box_size_x/y/z over the APB port (byte addresses 0, 4, 8) while the
//   block is idle. Voxels then stream in on s_tdata, x fastest, then y, then z.
//   After a box's last voxel one result transfer leaves on m_tdata with the
//   maximum and minimum (with their first local positions), the plain sum and
//   the x/y/z weighted sums. Other voxels produce no output.
//   Throughput: one voxel per cycle. A voxel enters the input register at the
//   edge that accepts it and is folded into the statistics when the statistics
//   stage takes it; m_tvalid rises at the edge that folds in the last voxel.
//   The output register holds a result while m_tready is low and voxels keep
//   flowing; input stalls only when the next box ends before that result is
//   taken.
//   Reset clears coordinates and statistics and sets all box sizes to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_box_extrema_and_moments (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // APB configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // Voxel input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [15:0]                 s_tdata,  // [15:0] voxel_value
  // Result stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [15:0] max_value, [25:16] max_pos_x, [35:26] max_pos_y, [45:36] max_pos_z,
  // [61:46] min_value, [71:62] min_pos_x, [81:72] min_pos_y, [91:82] min_pos_z,
  // [137:92] total_sum, [193:138] moment_x, [249:194] moment_y,
  // [305:250] moment_z, [311:306] zero
  output logic [vbox_pkg::TDATA_W-1:0]     m_tdata
);
  import vbox_pkg::*;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  size_t       box_size_x;
  size_t       box_size_y;
  size_t       box_size_z;
  logic        cfg_write;
  logic [1:0]  reg_index;
  logic        item_valid;
  voxel_item_t item;
  logic        take;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_size_x <= SIZE_BITS'(1);
      box_size_y <= SIZE_BITS'(1);
      box_size_z <= SIZE_BITS'(1);
    end else if (cfg_write) begin
      case (reg_index)
        REG_SIZE_X: box_size_x <= pwdata[SIZE_BITS-1:0];
        REG_SIZE_Y: box_size_y <= pwdata[SIZE_BITS-1:0];
        REG_SIZE_Z: box_size_z <= pwdata[SIZE_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_index)
      REG_SIZE_X: prdata = 32'(box_size_x);
      REG_SIZE_Y: prdata = 32'(box_size_y);
      REG_SIZE_Z: prdata = 32'(box_size_z);
      default:    prdata = '0;
    endcase
  end

  // Coordinate tagging and input register
  vbox_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_value    (s_tdata),
    .size_x     (box_size_x),
    .size_y     (box_size_y),
    .size_z     (box_size_z),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Statistics and result register
  vbox_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for voxel_box_extrema_and_moments
// Streams voxel boxes in scan order under several box shapes and flow-control
// patterns, predicts each box's extrema, positions, sum and first moments,
// and compares every result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import vbox_pkg::*;

  localparam int RUN_LIMIT    = 400_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS   = 60;
  localparam int HOLD_CYCLES  = 300;

  // Result layout; fields listed from the top bit down so the struct
  // overlays m_tdata directly (max_value ends up in the low bits)
  typedef struct packed {
    logic [PAD_W-1:0]    pad;
    logic [MOMENT_W-1:0] mom_z;
    logic [MOMENT_W-1:0] mom_y;
    logic [MOMENT_W-1:0] mom_x;
    logic [SUM_W-1:0]    total_sum;
    coord_t              min_z;
    coord_t              min_y;
    coord_t              min_x;
    sample_t             min_value;
    coord_t              max_z;
    coord_t              max_y;
    coord_t              max_x;
    sample_t             max_value;
  } box_stats_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [3:0]          paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata  = '0;  // [15:0] voxel_value
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;        // see box_stats_t, max_value lowest

  // Stimulus and scoreboard storage
  sample_t    voxel_q[$];
  box_stats_t box_stats_q[$];
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_left      = 0;
  bit         hold_go        = 1'b0;
  bit         hold_done      = 1'b0;
  int         fail_count     = 0;
  int         cycle_count    = 0;

  // Predictor state
  size_t      size_reg [3];
  coord_t     cnt_x, cnt_y, cnt_z;
  bit         first_in_box;
  sample_t    peak_val, floor_val;
  coord_t     peak_x, peak_y, peak_z;
  coord_t     floor_x, floor_y, floor_z;
  longint     sum_acc, mx_acc, my_acc, mz_acc;

  voxel_box_extrema_and_moments i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Effective voxel count along an axis: zero means one, large saturates
  function automatic int axis_len(size_t n);
    int k;
    k = int'(n);
    if (k == 0) k = 1;
    if (k > SIZE_CAP) k = SIZE_CAP;
    return k;
  endfunction

  task automatic clear_box();
    cnt_x = '0; cnt_y = '0; cnt_z = '0;
    first_in_box = 1'b1;
    peak_val = '0; floor_val = '0;
    {peak_x, peak_y, peak_z} = '0;
    {floor_x, floor_y, floor_z} = '0;
    sum_acc = 0; mx_acc = 0; my_acc = 0; mz_acc = 0;
  endtask

  // Fold one accepted voxel into the running box statistics
  task automatic accumulate_voxel(sample_t v);
    box_stats_t res;
    bit end_x, end_y, end_z;
    if (first_in_box || v > peak_val) begin
      peak_val = v; peak_x = cnt_x; peak_y = cnt_y; peak_z = cnt_z;
    end
    if (first_in_box || v < floor_val) begin
      floor_val = v; floor_x = cnt_x; floor_y = cnt_y; floor_z = cnt_z;
    end
    first_in_box = 1'b0;
    sum_acc += longint'(v);
    mx_acc  += longint'(v) * longint'(cnt_x);
    my_acc  += longint'(v) * longint'(cnt_y);
    mz_acc  += longint'(v) * longint'(cnt_z);

    // ">=" so a box shrunk mid-way closes early
    end_x = int'(cnt_x) >= axis_len(size_reg[0]) - 1;
    end_y = int'(cnt_y) >= axis_len(size_reg[1]) - 1;
    end_z = int'(cnt_z) >= axis_len(size_reg[2]) - 1;

    if (end_x && end_y && end_z) begin
      res.pad       = '0;
      res.max_value = peak_val;
      res.max_x     = peak_x;
      res.max_y     = peak_y;
      res.max_z     = peak_z;
      res.min_value = floor_val;
      res.min_x     = floor_x;
      res.min_y     = floor_y;
      res.min_z     = floor_z;
      res.total_sum = SUM_W'(sum_acc);
      res.mom_x     = MOMENT_W'(mx_acc);
      res.mom_y     = MOMENT_W'(my_acc);
      res.mom_z     = MOMENT_W'(mz_acc);
      box_stats_q.push_back(res);
      clear_box();
    end else if (!end_x) begin
      cnt_x++;
    end else begin
      cnt_x = '0;
      if (!end_y) begin
        cnt_y++;
      end else begin
        cnt_y = '0;
        cnt_z++;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    if (fail_count < MAX_PRINTS) $display("ERROR @%0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic check_box(box_stats_t got, box_stats_t want);
    check_field("max_value", got.max_value, want.max_value);
    check_field("max_pos_x", got.max_x, want.max_x);
    check_field("max_pos_y", got.max_y, want.max_y);
    check_field("max_pos_z", got.max_z, want.max_z);
    check_field("min_value", got.min_value, want.min_value);
    check_field("min_pos_x", got.min_x, want.min_x);
    check_field("min_pos_y", got.min_y, want.min_y);
    check_field("min_pos_z", got.min_z, want.min_z);
    check_field("total_sum", got.total_sum, want.total_sum);
    check_field("moment_x", got.mom_x, want.mom_x);
    check_field("moment_y", got.mom_y, want.mom_y);
    check_field("moment_z", got.mom_z, want.mom_z);
    check_field("pad", got.pad, want.pad);
  endtask

  // Voxel driver: next item offered once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (voxel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= voxel_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once on request and counted down
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver: random stalls, held off while the long hold runs
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results first, then predict from accepted voxels
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (box_stats_q.size() == 0) begin
          report_mismatch("result transfer with none expected");
        end else begin
          check_box(box_stats_t'(m_tdata), box_stats_q.pop_front());
        end
      end
      if (s_tvalid && s_tready) accumulate_voxel(sample_t'(s_tdata));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Register write: setup then access; predictor copy follows the write edge
  task automatic write_reg(int idx, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * idx);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < 3) size_reg[idx] = data[SIZE_BITS-1:0];
  endtask

  // Wait for all voxels taken, all results in, and the pipeline empty
  task automatic run_to_idle();
    while (voxel_q.size() != 0 || s_tvalid || box_stats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_box(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, output int vol);
    run_to_idle();
    write_reg(0, sx);
    write_reg(1, sy);
    write_reg(2, sz);
    vol = axis_len(sx[SIZE_BITS-1:0]) * axis_len(sy[SIZE_BITS-1:0]) *
          axis_len(sz[SIZE_BITS-1:0]);
  endtask

  // Mostly full-range samples, some extremes, some narrow values for ties
  function automatic sample_t pick_voxel();
    case ($urandom_range(9))
      0: return sample_t'(16'h7FFF);
      1: return sample_t'(16'h8000);
      2, 3: return sample_t'($urandom_range(6)) - sample_t'(3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Size write with occasional zero and random junk above the register
  function automatic logic [31:0] pick_size(int hi);
    logic [31:0] junk;
    junk = $urandom_range(1) ? ($urandom & 32'hFFFF_F800) : 32'h0;
    if ($urandom_range(19) == 0) return junk;
    return junk | 32'($urandom_range(1, hi));
  endfunction

  task automatic push_random(int n);
    repeat (n) voxel_q.push_back(pick_voxel());
  endtask

  // Random boxes of small shapes, now and then a cut-short box
  task automatic random_phase(int n_items);
    int sent;
    int vol;
    sent = 0;
    while (sent < n_items) begin
      set_box(pick_size(8), pick_size(4), pick_size(3), vol);
      repeat ($urandom_range(1, 4)) begin
        push_random(vol);
        sent += vol;
      end
      if ($urandom_range(3) == 0) begin
        vol = $urandom_range(1, vol);
        push_random(vol);
        sent += vol;
      end
    end
  endtask

  // One large axis; a 1x1x1 box first closes whatever box is open
  task automatic large_box(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    int vol;
    set_box(1, 1, 1, vol);
    voxel_q.push_back(pick_voxel());
    set_box(sx, sy, sz, vol);
    push_random(vol);
  endtask

  initial begin
    int vol;
    size_reg = '{default: size_t'(1)};
    clear_box();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single-voxel boxes at reset sizes
    voxel_q.push_back(sample_t'(16'h7FFF));
    voxel_q.push_back(sample_t'(16'h8000));
    voxel_q.push_back(sample_t'(0));
    voxel_q.push_back(sample_t'(-1));
    voxel_q.push_back(sample_t'(1));

    // 2x2x2 with repeated extremes: the first occurrence must win
    set_box(2, 2, 2, vol);
    write_reg(3, 32'd5);  // beyond the register list, no effect
    voxel_q.push_back(sample_t'(5));
    voxel_q.push_back(sample_t'(5));
    voxel_q.push_back(sample_t'(-7));
    voxel_q.push_back(sample_t'(16'h7FFF));
    voxel_q.push_back(sample_t'(16'h7FFF));
    voxel_q.push_back(sample_t'(16'h8000));
    voxel_q.push_back(sample_t'(16'h8000));
    voxel_q.push_back(sample_t'(0));

    // Zero sizes act as one
    set_box(32'hFFFF_F800, 0, 0, vol);
    voxel_q.push_back(sample_t'(100));
    voxel_q.push_back(sample_t'(-100));

    // Box shrunk mid-way closes on the next voxel
    set_box(4, 2, 1, vol);
    push_random(5);
    run_to_idle();
    write_reg(0, 2);
    voxel_q.push_back(pick_voxel());

    // Receiver held off while the sender keeps offering one-voxel boxes
    set_box(1, 1, 1, vol);
    hold_go <= 1'b1;
    push_random(40);

    large_box(200, 1, 1);
    random_phase(80);

    send_idle_pct  = 63;
    recv_stall_pct = 0;
    random_phase(80);
    large_box(1, 150, 1);

    send_idle_pct  = 0;
    recv_stall_pct = 63;
    random_phase(80);
    large_box(1, 1, 120);

    send_idle_pct  = 11;
    recv_stall_pct = 11;
    random_phase(80);

    run_to_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/vbox_pkg.sv
rtl/vbox_scan.sv
rtl/vbox_stats.sv
rtl/voxel_box_extrema_and_moments.sv
verif/tb.sv
